@@ rtl/tcpf_pkg.sv @@
// Shared types and constants for the two-class priority FIFO.
package tcpf_pkg;

    localparam int KEY_W = 32;
    localparam int TOTAL_W = 5;

    typedef enum logic [1:0] {
        OP_ENQ_NORMAL   = 2'd0,
        OP_ENQ_PRIORITY = 2'd1,
        OP_SERVE        = 2'd2,
        OP_COUNT        = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_cmd;

endpackage

@@ rtl/tcpf_if.sv @@
// Valid/ready channel interfaces for input and result transactions.
interface tcpf_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [tcpf_pkg::KEY_W-1:0]   key_value;

    modport source (output valid, output opcode, output key_value, input ready);
    modport sink (input valid, input opcode, input key_value, output ready);
endinterface

interface tcpf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tcpf_pkg::KEY_W-1:0]   served_key;
    logic [1:0]                          status;
    logic                                from_priority;
    logic [tcpf_pkg::TOTAL_W-1:0]        remaining_total;

    modport source (output valid, output served_key, output status,
                    output from_priority, output remaining_total, input ready);
    modport sink (input valid, input served_key, input status,
                  input from_priority, input remaining_total, output ready);
endinterface

@@ rtl/tcpf_cell.sv @@
// One storage cell of a queue: loads a new key or takes its neighbor's key.
module tcpf_cell (
    input  logic                        i_clk,
    input  tcpf_pkg::t_cell_ctl         i_ctl,
    input  logic [tcpf_pkg::KEY_W-1:0]  i_key,
    input  logic [tcpf_pkg::KEY_W-1:0]  i_neighbor,
    output logic [tcpf_pkg::KEY_W-1:0]  o_data
);

    logic [tcpf_pkg::KEY_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_neighbor;
        end else if (i_ctl.load) begin
            r_data <= i_key;
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/tcpf_queue.sv @@
// One bounded queue built as a row of cells with the head in cell zero.
module tcpf_queue #(
    parameter int QUEUE_DEPTH = 8,
    parameter int CNT_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcpf_pkg::t_queue_cmd        i_cmd,
    input  logic [tcpf_pkg::KEY_W-1:0]  i_key,
    output logic [tcpf_pkg::KEY_W-1:0]  o_head,
    output logic [CNT_W-1:0]            o_count,
    output logic [CNT_W-1:0]            o_count_next,
    output logic                        o_full,
    output logic                        o_empty
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [tcpf_pkg::KEY_W-1:0] w_data [QUEUE_DEPTH+1];

    assign w_data[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tcpf_pkg::t_cell_ctl w_ctl;

        assign w_ctl.shift = i_cmd.pop;
        assign w_ctl.load  = i_cmd.push && (r_count == CNT_W'(g));

        tcpf_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key      (i_key),
            .i_neighbor (w_data[g+1]),
            .o_data     (w_data[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head       = w_data[0];
    assign o_count      = r_count;
    assign o_count_next = n_count;
    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty      = (r_count == '0);

endmodule

@@ rtl/two_class_priority_fifo_core.sv @@
// Top level of the two-class strict-priority FIFO scheduler.
// Every queue update is a single cell-row shift or load; each accepted result is registered.
// Throughput: one transaction per cycle while the sink takes each result.
// A new transaction is taken while the previous result waits, if the sink takes it that cycle.
// Reset empties both queues and the output register; cell contents are not cleared.
module two_class_priority_fifo_core #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcpf_in_if.sink     i_in,
    tcpf_out_if.source  o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = (CNT_W + 1 > tcpf_pkg::TOTAL_W) ? CNT_W + 1 : tcpf_pkg::TOTAL_W;

    tcpf_pkg::t_opcode    w_op;
    tcpf_pkg::t_queue_cmd w_cmd_n;
    tcpf_pkg::t_queue_cmd w_cmd_p;
    logic                 w_accept;
    logic [tcpf_pkg::KEY_W-1:0] w_head_n;
    logic [tcpf_pkg::KEY_W-1:0] w_head_p;
    logic [CNT_W-1:0]     w_cnt_n;
    logic [CNT_W-1:0]     w_cnt_p;
    logic [CNT_W-1:0]     w_cnt_next_n;
    logic [CNT_W-1:0]     w_cnt_next_p;
    logic                 w_full_n;
    logic                 w_full_p;
    logic                 w_empty_n;
    logic                 w_empty_p;
    logic [SUM_W-1:0]     w_total;

    logic [tcpf_pkg::KEY_W-1:0] n_served;
    tcpf_pkg::t_status          n_status;
    logic                       n_from_pri;

    logic                       r_out_valid;
    logic [tcpf_pkg::KEY_W-1:0] r_served;
    tcpf_pkg::t_status          r_status;
    logic                       r_from_pri;
    logic [tcpf_pkg::TOTAL_W-1:0] r_total;

    assign w_op     = tcpf_pkg::t_opcode'(i_in.opcode);
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && i_in.ready;

    assign w_cmd_n.push = w_accept && (w_op == tcpf_pkg::OP_ENQ_NORMAL) && !w_full_n;
    assign w_cmd_p.push = w_accept && (w_op == tcpf_pkg::OP_ENQ_PRIORITY) && !w_full_p;
    assign w_cmd_p.pop  = w_accept && (w_op == tcpf_pkg::OP_SERVE) && !w_empty_p;
    assign w_cmd_n.pop  = w_accept && (w_op == tcpf_pkg::OP_SERVE) && w_empty_p && !w_empty_n;

    tcpf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_normal (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd_n),
        .i_key        (i_in.key_value),
        .o_head       (w_head_n),
        .o_count      (w_cnt_n),
        .o_count_next (w_cnt_next_n),
        .o_full       (w_full_n),
        .o_empty      (w_empty_n)
    );

    tcpf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .CNT_W(CNT_W)) u_priority (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd_p),
        .i_key        (i_in.key_value),
        .o_head       (w_head_p),
        .o_count      (w_cnt_p),
        .o_count_next (w_cnt_next_p),
        .o_full       (w_full_p),
        .o_empty      (w_empty_p)
    );

    assign w_total = SUM_W'(w_cnt_next_n) + SUM_W'(w_cnt_next_p);

    always_comb begin
        n_served   = '0;
        n_status   = tcpf_pkg::ST_EMPTY;
        n_from_pri = 1'b0;
        unique case (w_op)
            tcpf_pkg::OP_ENQ_NORMAL: begin
                n_status = w_full_n ? tcpf_pkg::ST_DROPPED : tcpf_pkg::ST_ENQUEUED;
            end
            tcpf_pkg::OP_ENQ_PRIORITY: begin
                n_status = w_full_p ? tcpf_pkg::ST_DROPPED : tcpf_pkg::ST_ENQUEUED;
            end
            tcpf_pkg::OP_SERVE: begin
                if (!w_empty_p) begin
                    n_served   = w_head_p;
                    n_status   = tcpf_pkg::ST_SERVED;
                    n_from_pri = 1'b1;
                end else if (!w_empty_n) begin
                    n_served = w_head_n;
                    n_status = tcpf_pkg::ST_SERVED;
                end
            end
            default: begin
                n_status = tcpf_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_served   <= n_served;
            r_status   <= n_status;
            r_from_pri <= n_from_pri;
            r_total    <= w_total[tcpf_pkg::TOTAL_W-1:0];
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.served_key      = r_served;
    assign o_out.status          = r_status;
    assign o_out.from_priority   = r_from_pri;
    assign o_out.remaining_total = r_total;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cnt_n <= CNT_W'(QUEUE_DEPTH)) && (w_cnt_p <= CNT_W'(QUEUE_DEPTH)))
        else $error("Queue count exceeds depth.");

    a_enq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == tcpf_pkg::OP_ENQ_NORMAL) && !w_full_n)
        |=> (r_status == tcpf_pkg::ST_ENQUEUED))
        else $error("Enqueue into a non-full queue was not reported as enqueued.");

    a_pri_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == tcpf_pkg::OP_SERVE) && !w_empty_p)
        |=> (r_from_pri && (r_status == tcpf_pkg::ST_SERVED)))
        else $error("Serve did not take from the non-empty priority queue.");

    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd_n.pop && w_cmd_p.pop))
        else $error("Both queues popped in one transaction.");

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the two-class strict-priority FIFO scheduler.
`timescale 1ns / 100ps

module tb_top;

    localparam int DEPTH       = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 175;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [tcpf_pkg::KEY_W-1:0] key;
        tcpf_pkg::t_status                 status;
        logic                              from_pri;
        logic [tcpf_pkg::TOTAL_W-1:0]      total;
    } t_sched_result;

    class sched_scoreboard;
        int depth;
        logic signed [tcpf_pkg::KEY_W-1:0] normal_keys[$];
        logic signed [tcpf_pkg::KEY_W-1:0] priority_keys[$];
        t_sched_result owed_results[$];
        int failures;
        int checked;
        int served_pri;
        int served_norm;
        int drops;
        int empties;

        function new(int queue_depth);
            depth = queue_depth;
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        function void note_accepted(tcpf_pkg::t_opcode op,
                                    logic signed [tcpf_pkg::KEY_W-1:0] key);
            t_sched_result r;
            r.key = '0;
            r.status = tcpf_pkg::ST_EMPTY;
            r.from_pri = 1'b0;
            case (op)
                tcpf_pkg::OP_ENQ_NORMAL: begin
                    if (normal_keys.size() < depth) begin
                        normal_keys.push_back(key);
                        r.status = tcpf_pkg::ST_ENQUEUED;
                    end else begin
                        r.status = tcpf_pkg::ST_DROPPED;
                    end
                end
                tcpf_pkg::OP_ENQ_PRIORITY: begin
                    if (priority_keys.size() < depth) begin
                        priority_keys.push_back(key);
                        r.status = tcpf_pkg::ST_ENQUEUED;
                    end else begin
                        r.status = tcpf_pkg::ST_DROPPED;
                    end
                end
                tcpf_pkg::OP_SERVE: begin
                    if (priority_keys.size() != 0) begin
                        r.key = priority_keys.pop_front();
                        r.status = tcpf_pkg::ST_SERVED;
                        r.from_pri = 1'b1;
                    end else if (normal_keys.size() != 0) begin
                        r.key = normal_keys.pop_front();
                        r.status = tcpf_pkg::ST_SERVED;
                    end
                end
                default: ;
            endcase
            r.total = tcpf_pkg::TOTAL_W'(normal_keys.size() + priority_keys.size());
            owed_results.push_back(r);
        endfunction

        function void check_result(logic signed [tcpf_pkg::KEY_W-1:0] key,
                                   logic [1:0] status, logic from_pri,
                                   logic [tcpf_pkg::TOTAL_W-1:0] total);
            t_sched_result e;
            if (owed_results.size() == 0) begin
                $error("unexpected result transaction: status %0d, served_key %0d",
                       status, key);
                failures++;
                return;
            end
            e = owed_results.pop_front();
            checked++;
            if (key !== e.key) begin
                $error("served_key: expected %0d, actual %0d", e.key, key);
                failures++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                failures++;
            end
            if (from_pri !== e.from_pri) begin
                $error("from_priority: expected %0d, actual %0d", e.from_pri, from_pri);
                failures++;
            end
            if (total !== e.total) begin
                $error("remaining_total: expected %0d, actual %0d", e.total, total);
                failures++;
            end
            case (e.status)
                tcpf_pkg::ST_SERVED: if (e.from_pri) served_pri++; else served_norm++;
                tcpf_pkg::ST_DROPPED: drops++;
                tcpf_pkg::ST_EMPTY: empties++;
                default: ;
            endcase
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   src_eager;
    bit   sink_eager;
    bit   hold_req;
    int   hold_left;
    int   run_left;
    int   stall_left;

    tcpf_in_if  in_ch();
    tcpf_out_if out_ch();

    sched_scoreboard sb = new(DEPTH);

    two_class_priority_fifo_core #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int gap_len(bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic tcpf_pkg::t_opcode pick_op(int bias);
        int r;
        int enq_pct;
        r = $urandom_range(0, 99);
        case (bias)
            1: enq_pct = 70;
            2: enq_pct = 25;
            default: enq_pct = 48;
        endcase
        if (r < enq_pct) begin
            if (bias == 3)
                return ($urandom_range(0, 3) == 0) ? tcpf_pkg::OP_ENQ_NORMAL
                                                   : tcpf_pkg::OP_ENQ_PRIORITY;
            return $urandom_range(0, 1) ? tcpf_pkg::OP_ENQ_PRIORITY
                                        : tcpf_pkg::OP_ENQ_NORMAL;
        end
        if (r < 94) return tcpf_pkg::OP_SERVE;
        return tcpf_pkg::OP_COUNT;
    endfunction

    function automatic logic signed [tcpf_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 19))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** two_class_priority_fifo_core: FAILED **");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_req) begin
                hold_req <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (run_left != 0) begin
                out_ch.ready <= 1'b1;
                run_left--;
            end else if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                run_left = $urandom_range(0, 12);
                stall_left = gap_len(sink_eager);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.served_key, out_ch.status, out_ch.from_priority,
                            out_ch.remaining_total);
    end

    task automatic put_item(tcpf_pkg::t_opcode op, logic signed [tcpf_pkg::KEY_W-1:0] key);
        int idle;
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.key_value <= key;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_accepted(op, key);
        idle = gap_len(src_eager);
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            in_ch.opcode <= 2'($urandom);
            in_ch.key_value <= $urandom;
            repeat (idle) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.owed() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int phase;
        int n;
        int bias;
        rst_n = 1'b0;
        cycles = 0;
        src_eager = 1'b0;
        sink_eager = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        run_left = 0;
        stall_left = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = tcpf_pkg::OP_COUNT;
        in_ch.key_value = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        put_item(tcpf_pkg::OP_SERVE, 32'sh1234_5678);
        put_item(tcpf_pkg::OP_COUNT, '0);
        put_item(tcpf_pkg::OP_ENQ_NORMAL, 32'sh7FFF_FFFF);
        put_item(tcpf_pkg::OP_ENQ_NORMAL, 32'sh8000_0000);
        put_item(tcpf_pkg::OP_ENQ_NORMAL, '0);
        put_item(tcpf_pkg::OP_ENQ_NORMAL, '1);
        for (n = 0; n < DEPTH + 1; n++)
            put_item(tcpf_pkg::OP_ENQ_PRIORITY, n[0] ? 32'sh5555_5555 : 32'shAAAA_AAAA);
        put_item(tcpf_pkg::OP_COUNT, '1);
        for (n = 0; n < DEPTH - 3; n++)
            put_item(tcpf_pkg::OP_ENQ_NORMAL, n[0] ? 32'sh0F0F_0F0F : 32'shF0F0_F0F0);
        put_item(tcpf_pkg::OP_COUNT, 32'sh5555_5555);
        for (n = 0; n < 3; n++)
            put_item(tcpf_pkg::OP_SERVE, '1);
        wait_drained();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                1: bias = 1;
                2: bias = 1;
                3: bias = 2;
                5: bias = 3;
                6: bias = 2;
                default: bias = 0;
            endcase
            src_eager = (phase == 1 || phase == 4);
            sink_eager <= (phase == 4);
            if (phase == 2)
                hold_req <= 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                put_item(pick_op(bias), pick_key());
            if (phase % 3 == 2)
                wait_drained();
        end
        wait_drained();

        $display("Checked %0d result transactions: %0d served from priority, %0d from normal,",
                 sb.checked, sb.served_pri, sb.served_norm);
        $display("%0d dropped on a full queue, %0d with nothing to serve or count only.",
                 sb.drops, sb.empties);
        if (sb.failures == 0)
            $display("** two_class_priority_fifo_core: PASSED **");
        else
            $display("** two_class_priority_fifo_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tcpf_pkg.sv
rtl/tcpf_if.sv
rtl/tcpf_cell.sv
rtl/tcpf_queue.sv
rtl/two_class_priority_fifo_core.sv
bench/tb_top.sv
